>>> hw/rtl/multilevel_queue_scheduler_assert.svh
// assertion macros for the scheduler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MQS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MQS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mqs_pkg.sv
// shared types, codes and constants of the multilevel queue scheduler
// no dependencies; used by every rtl file of the block but mqs_ram
package mqs_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int QUEUE_DEPTH       = 2;

   localparam int SLOT_W    = 6;
   localparam int LEVEL_W   = 2;
   localparam int ORDER_W   = 32;
   localparam int TIME_W    = 32;
   localparam int SIZE_W    = 32;
   localparam int PRIO_W    = 7;
   localparam int WEIGHT_W  = 16;
   localparam int TENTHS_W  = 32;
   localparam int RANK_W    = 50;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [TIME_W-1:0]   AGING_LIMIT_RST     = 32'd1000;
   localparam logic [WEIGHT_W-1:0] DEF_WEIGHT_RST      = 16'd51;
   localparam logic [WEIGHT_W-1:0] DEF_SIZE_WEIGHT_RST = 16'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AGING_LIMIT         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_WEIGHT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SIZE_WEIGHT = 2'd2;

   // queue level held per entry
   localparam logic [LEVEL_W-1:0] LVL_EMPTY = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_RR    = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_LCFS  = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_BJF   = 2'd3;

   // served level reported with a result
   localparam logic [LEVEL_W-1:0] SRV_RR   = 2'd0;
   localparam logic [LEVEL_W-1:0] SRV_LCFS = 2'd1;
   localparam logic [LEVEL_W-1:0] SRV_BJF  = 2'd2;

   // rank arithmetic: divide by 2560 as shift by 9, then divide by 5 in two halves
   localparam int RANK_STAGES = 7;
   localparam int HALF_W      = 23;
   localparam int HI_SHIFT    = 26;
   localparam int LO_SHIFT    = 29;
   localparam logic [23:0] RECIP_HI = 24'd13421773;   // ceil(2^26 / 5)
   localparam logic [26:0] RECIP_LO = 27'd107374183;  // ceil(2^29 / 5)

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_WEIGHTS = 2'd1,
      OP_YIELD   = 2'd2,
      OP_SCHED   = 2'd3
   } op_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] wt_size;
      logic [WEIGHT_W-1:0] wt_exec;
      logic [WEIGHT_W-1:0] wt_arrival;
      logic [WEIGHT_W-1:0] wt_prio;
   } weight_type;

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [SIZE_W-1:0]  size;
      logic [TIME_W-1:0]  created;
      logic [ORDER_W-1:0] order;
   } info_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic                runnable;
      logic [LEVEL_W-1:0]  level;
      info_type            info;
      weight_type          weights;
   } item_type;

endpackage

>>> hw/rtl/multilevel_queue_scheduler.sv
// top level of the multilevel queue scheduler: config registers, front and back end
// depends on mqs_pkg, mqs_front, mqs_back
//
//   channel | prefix | handshake          | moves
//   request | req_   | valid / ready      | one command with its entry fields
//   result  | rsp_   | valid / ready      | one pick per schedule command
//   config  | csr_   | write enable only  | register index and data
//
// entry write and set weights complete in the back end's idle state, yield adds a state for the tenths update
// a schedule is a read scan of the tables plus the rank pipeline, then, after a
// successful pick, an aging pass that reads each entry once
// after reset a clearing pass over every table entry runs before requests transfer
// a two-entry queue keeps taking requests while the back end works or a result waits, until it fills
module multilevel_queue_scheduler #(
   parameter int TABLE_ENTRIES = mqs_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [mqs_pkg::SLOT_W-1:0]        req_slot,
   input  logic                              req_runnable,
   input  logic [mqs_pkg::LEVEL_W-1:0]       req_queue_level,
   input  logic [mqs_pkg::ORDER_W-1:0]       req_arrival_order,
   input  logic [mqs_pkg::TIME_W-1:0]        req_time_stamp,
   input  logic [mqs_pkg::SIZE_W-1:0]        req_task_size,
   input  logic [mqs_pkg::PRIO_W-1:0]        req_base_priority,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_priority,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_arrival,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_executed,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_size,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [mqs_pkg::SLOT_W-1:0]        rsp_chosen_slot,
   output logic [mqs_pkg::LEVEL_W-1:0]       rsp_served_level,
   output logic [mqs_pkg::RANK_W-1:0]        rsp_chosen_rank,
   input  logic                              csr_we,
   input  logic [mqs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mqs_pkg::CSR_W-1:0]         csr_wdata
);

   logic [mqs_pkg::TIME_W-1:0]   aging_limit_ff;
   logic [mqs_pkg::WEIGHT_W-1:0] def_weight_ff;
   logic [mqs_pkg::WEIGHT_W-1:0] def_size_weight_ff;

   logic              q_valid, q_pop, clearing;
   mqs_pkg::item_type q_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         aging_limit_ff     <= mqs_pkg::AGING_LIMIT_RST;
         def_weight_ff      <= mqs_pkg::DEF_WEIGHT_RST;
         def_size_weight_ff <= mqs_pkg::DEF_SIZE_WEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            mqs_pkg::CSR_AGING_LIMIT: begin
               aging_limit_ff <= csr_wdata;
            end
            mqs_pkg::CSR_DEFAULT_WEIGHT: begin
               def_weight_ff <= csr_wdata[mqs_pkg::WEIGHT_W-1:0];
            end
            mqs_pkg::CSR_DEFAULT_SIZE_WEIGHT: begin
               def_size_weight_ff <= csr_wdata[mqs_pkg::WEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   mqs_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_slot(req_slot),
      .req_runnable(req_runnable),
      .req_queue_level(req_queue_level),
      .req_arrival_order(req_arrival_order),
      .req_time_stamp(req_time_stamp),
      .req_task_size(req_task_size),
      .req_base_priority(req_base_priority),
      .req_weight_priority(req_weight_priority),
      .req_weight_arrival(req_weight_arrival),
      .req_weight_executed(req_weight_executed),
      .req_weight_size(req_weight_size),
      .hold(clearing),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   mqs_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .clearing(clearing),
      .aging_limit(aging_limit_ff),
      .def_weight(def_weight_ff),
      .def_size_weight(def_size_weight_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_chosen_slot(rsp_chosen_slot),
      .rsp_served_level(rsp_served_level),
      .rsp_chosen_rank(rsp_chosen_rank)
   );

endmodule

>>> hw/rtl/mqs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module mqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/mqs_rank.sv
// pipelined weighted rank of one table entry, one entry per cycle
// depends on mqs_pkg
module mqs_rank #(
   parameter int IDX_W = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [IDX_W-1:0]                     in_idx,
   input  logic                                 in_cand,
   input  mqs_pkg::info_type                    in_info,
   input  logic [mqs_pkg::TENTHS_W-1:0]         in_tenths,
   input  mqs_pkg::weight_type                  in_weights,
   output logic                                 out_valid,
   output logic [IDX_W-1:0]                     out_idx,
   output logic                                 out_cand,
   output logic [mqs_pkg::RANK_W-1:0]           out_rank,
   output logic                                 busy
);

   localparam int NS         = mqs_pkg::RANK_STAGES;
   localparam int HALF_W_IDX = mqs_pkg::HALF_W;

   logic [NS-1:0]    v_ff;
   logic [IDX_W-1:0] idx_ff  [NS];
   logic             cand_ff [NS];

   logic [22:0] pp_ff;
   logic [47:0] pc_ff, ps_ff, pt_ff;
   logic [49:0] base_ff;
   logic [47:0] pt2_ff;
   logic [45:0] y_ff;
   logic [20:0] qh4_ff, qh5_ff, qh6_ff;
   logic [22:0] yh4_ff, yl4_ff;
   logic [25:0] v5_ff;
   logic [23:0] ql6_ff;
   logic [49:0] rank_ff;

   logic [54:0] total;
   logic [46:0] prod_hi;
   logic [22:0] rem_full;
   logic [52:0] prod_lo;
   logic [43:0] quot;

   // total = 10 * base + tenths * we, then the shift by 9
   assign total    = 55'({base_ff, 3'b000}) + 55'({base_ff, 1'b0}) + 55'(pt2_ff);
   // high half divided by 5
   assign prod_hi  = y_ff[45:HALF_W_IDX] * mqs_pkg::RECIP_HI;
   // remainder of the high half
   assign rem_full = yh4_ff - 23'({qh4_ff, 2'b00}) - 23'(qh4_ff);
   // low half with carried remainder divided by 5
   assign prod_lo  = v5_ff * mqs_pkg::RECIP_LO;
   assign quot     = 44'({qh6_ff, 23'd0}) + 44'(ql6_ff);

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   // tags and arithmetic stages
   always_ff @(posedge clock) begin
      idx_ff[0]  <= in_idx;
      cand_ff[0] <= in_cand;
      for (int s = 1; s < NS; s++) begin
         idx_ff[s]  <= idx_ff[s-1];
         cand_ff[s] <= cand_ff[s-1];
      end
      pp_ff   <= in_info.prio * in_weights.wt_prio;
      pc_ff   <= in_info.created * in_weights.wt_arrival;
      ps_ff   <= in_info.size * in_weights.wt_size;
      pt_ff   <= in_tenths * in_weights.wt_exec;
      base_ff <= 50'(pp_ff) + 50'(pc_ff) + 50'(ps_ff);
      pt2_ff  <= pt_ff;
      y_ff    <= total[54:9];
      qh4_ff  <= prod_hi[46:mqs_pkg::HI_SHIFT];
      yh4_ff  <= y_ff[45:HALF_W_IDX];
      yl4_ff  <= y_ff[HALF_W_IDX-1:0];
      v5_ff   <= {rem_full[2:0], yl4_ff};
      qh5_ff  <= qh4_ff;
      ql6_ff  <= prod_lo[52:mqs_pkg::LO_SHIFT];
      qh6_ff  <= qh5_ff;
      // the largest total stays below 2^54, so the rank never reaches the 50-bit ceiling
      rank_ff <= 50'(quot);
   end

   assign out_valid = v_ff[NS-1];
   assign out_idx   = idx_ff[NS-1];
   assign out_cand  = cand_ff[NS-1];
   assign out_rank  = rank_ff;
   assign busy      = |v_ff;

endmodule

>>> hw/rtl/mqs_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on mqs_pkg
module mqs_front #(
   parameter int TABLE_ENTRIES = mqs_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [mqs_pkg::SLOT_W-1:0]        req_slot,
   input  logic                              req_runnable,
   input  logic [mqs_pkg::LEVEL_W-1:0]       req_queue_level,
   input  logic [mqs_pkg::ORDER_W-1:0]       req_arrival_order,
   input  logic [mqs_pkg::TIME_W-1:0]        req_time_stamp,
   input  logic [mqs_pkg::SIZE_W-1:0]        req_task_size,
   input  logic [mqs_pkg::PRIO_W-1:0]        req_base_priority,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_priority,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_arrival,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_executed,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      req_weight_size,
   input  logic                              hold,
   output logic                              q_valid,
   output mqs_pkg::item_type                 q_item,
   input  logic                              q_pop
);

   localparam int PTR_W = (mqs_pkg::QUEUE_DEPTH > 1) ? $clog2(mqs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mqs_pkg::QUEUE_DEPTH + 1);

   mqs_pkg::item_type q_ff [mqs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   mqs_pkg::item_type item_in;
   logic              in_range;
   logic              transfer;
   logic              keep;

   // classify the incoming request
   always_comb begin
      item_in.op               = mqs_pkg::op_type'(req_command);
      item_in.slot             = req_slot;
      item_in.runnable         = req_runnable;
      item_in.level            = req_queue_level;
      item_in.info.prio        = req_base_priority;
      item_in.info.size        = req_task_size;
      item_in.info.created     = req_time_stamp;
      item_in.info.order       = req_arrival_order;
      item_in.weights.wt_prio    = req_weight_priority;
      item_in.weights.wt_arrival = req_weight_arrival;
      item_in.weights.wt_exec    = req_weight_executed;
      item_in.weights.wt_size    = req_weight_size;
   end

   assign in_range  = 32'(req_slot) < 32'(TABLE_ENTRIES);
   assign req_ready = (count_ff != CNT_W'(mqs_pkg::QUEUE_DEPTH)) && !hold;
   assign transfer  = req_valid && req_ready;
   // table commands beyond the table do nothing, so they are dropped here
   assign keep      = transfer && ((item_in.op == mqs_pkg::OP_SCHED) || in_range);

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (keep) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mqs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mqs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (keep && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!keep && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = q_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/mqs_back.sv
// back end: entry tables, selection scan, aging pass and result register
// depends on mqs_pkg, mqs_ram, mqs_rank and the assertion header
`include "multilevel_queue_scheduler_assert.svh"

module mqs_back #(
   parameter int TABLE_ENTRIES = mqs_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mqs_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              clearing,
   input  logic [mqs_pkg::TIME_W-1:0]        aging_limit,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      def_weight,
   input  logic [mqs_pkg::WEIGHT_W-1:0]      def_size_weight,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [mqs_pkg::SLOT_W-1:0]        rsp_chosen_slot,
   output logic [mqs_pkg::LEVEL_W-1:0]       rsp_served_level,
   output logic [mqs_pkg::RANK_W-1:0]        rsp_chosen_rank
);

   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int INFO_W   = $bits(mqs_pkg::info_type);
   localparam int WEIGHT_T = $bits(mqs_pkg::weight_type);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_YIELD   = 8'b0000_0100,
      ST_SCAN    = 8'b0000_1000,
      ST_DRAIN   = 8'b0001_0000,
      ST_DECIDE  = 8'b0010_0000,
      ST_AGE     = 8'b0100_0000,
      ST_AGE_END = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              iss_v_ff;
   logic [IDX_W-1:0]  iss_idx_ff;
   mqs_pkg::item_type cur_ff;

   logic                        c1_found_ff, c2_found_ff, c3_found_ff;
   logic [IDX_W-1:0]            c1_idx_ff, c2_idx_ff, c3_idx_ff;
   logic [mqs_pkg::ORDER_W-1:0] c2_order_ff;
   logic [mqs_pkg::RANK_W-1:0]  c3_rank_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [mqs_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [mqs_pkg::LEVEL_W-1:0] rsp_level_ff;
   logic [mqs_pkg::RANK_W-1:0]  rsp_rank_ff;

   // memory ports
   logic [IDX_W-1:0]             rd_addr, wr_addr;
   logic                         ready_we, level_we, info_we, tenths_we, weight_we;
   logic                         ready_wdata;
   logic [mqs_pkg::LEVEL_W-1:0]  level_wdata;
   logic [mqs_pkg::TENTHS_W-1:0] tenths_wdata;
   mqs_pkg::weight_type          weight_wdata;
   logic                         ready_rd;
   logic [mqs_pkg::LEVEL_W-1:0]  level_rd;
   logic [INFO_W-1:0]            info_raw;
   mqs_pkg::info_type            info_rd;
   logic [mqs_pkg::TENTHS_W-1:0] tenths_rd;
   logic [WEIGHT_T-1:0]          weight_raw;

   logic [31:0]                  head_slot_ext, cur_slot_ext;
   logic [IDX_W-1:0]             head_idx, cur_idx, cnt_idx, pick_idx;
   logic                         last_cnt, issue, cand_clear;
   logic                         scan_v, age_v, age_hit;
   logic                         any_found, rsp_free, rsp_load;
   logic [mqs_pkg::LEVEL_W-1:0]  pick_level;
   logic [mqs_pkg::RANK_W-1:0]   pick_rank;
   logic [mqs_pkg::TIME_W-1:0]   age;

   logic                         rk_valid, rk_cand, rank_busy;
   logic [IDX_W-1:0]             rk_idx;
   logic [mqs_pkg::RANK_W-1:0]   rk_rank;

   assign head_slot_ext = 32'(q_item.slot);
   assign cur_slot_ext  = 32'(cur_ff.slot);
   assign head_idx      = head_slot_ext[IDX_W-1:0];
   assign cur_idx       = cur_slot_ext[IDX_W-1:0];
   assign cnt_idx       = cnt_ff[IDX_W-1:0];
   assign last_cnt      = (cnt_ff == CNT_W'(TABLE_ENTRIES - 1));
   assign info_rd       = mqs_pkg::info_type'(info_raw);
   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign scan_v        = iss_v_ff && ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN));
   assign age_v         = iss_v_ff && ((state_ff == ST_AGE) || (state_ff == ST_AGE_END));
   assign age           = cur_ff.info.created - info_rd.created;
   assign age_hit       = ((level_rd == mqs_pkg::LVL_LCFS) || (level_rd == mqs_pkg::LVL_BJF))
                          && (age > aging_limit);
   assign any_found     = c1_found_ff || c2_found_ff || c3_found_ff;

   // level priority among the three candidates
   always_comb begin
      pick_idx   = '0;
      pick_level = mqs_pkg::SRV_RR;
      pick_rank  = '0;
      if (c1_found_ff) begin
         pick_idx = c1_idx_ff;
      end else if (c2_found_ff) begin
         pick_idx   = c2_idx_ff;
         pick_level = mqs_pkg::SRV_LCFS;
      end else if (c3_found_ff) begin
         pick_idx   = c3_idx_ff;
         pick_level = mqs_pkg::SRV_BJF;
         pick_rank  = c3_rank_ff;
      end
   end

   // sequencer and memory port control
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      issue        = 1'b0;
      cand_clear   = 1'b0;
      rsp_load     = 1'b0;
      rd_addr      = cnt_idx;
      wr_addr      = head_idx;
      ready_we     = 1'b0;
      level_we     = 1'b0;
      info_we      = 1'b0;
      tenths_we    = 1'b0;
      weight_we    = 1'b0;
      ready_wdata  = 1'b0;
      level_wdata  = mqs_pkg::LVL_EMPTY;
      tenths_wdata = '0;
      weight_wdata = q_item.weights;
      case (state_ff)
         ST_CLEAR: begin
            // one entry per cycle back to empty and not runnable
            wr_addr  = cnt_idx;
            ready_we = 1'b1;
            level_we = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = head_idx;
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  mqs_pkg::OP_WRITE: begin
                     ready_we     = 1'b1;
                     level_we     = 1'b1;
                     info_we      = 1'b1;
                     tenths_we    = 1'b1;
                     weight_we    = 1'b1;
                     ready_wdata  = q_item.runnable;
                     level_wdata  = q_item.level;
                     weight_wdata = '{wt_size: def_size_weight, wt_exec: def_weight,
                                      wt_arrival: def_weight, wt_prio: def_weight};
                  end
                  mqs_pkg::OP_WEIGHTS: begin
                     weight_we = 1'b1;
                  end
                  mqs_pkg::OP_YIELD: begin
                     ready_we    = 1'b1;
                     ready_wdata = 1'b1;
                     state_in    = ST_YIELD;
                  end
                  mqs_pkg::OP_SCHED: begin
                     cand_clear = 1'b1;
                     cnt_in     = '0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_YIELD: begin
            // saturating increment of the executed tenths
            wr_addr      = cur_idx;
            tenths_we    = 1'b1;
            tenths_wdata = (tenths_rd == '1) ? tenths_rd : tenths_rd + 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!iss_v_ff && !rank_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            wr_addr = pick_idx;
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (any_found) begin
                  ready_we = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_AGE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_AGE: begin
            wr_addr = iss_idx_ff;
            issue   = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_AGE_END;
            end
         end
         ST_AGE_END: begin
            wr_addr  = iss_idx_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // promotion of old entries, one read behind the issue
      if (age_v && age_hit) begin
         level_we    = 1'b1;
         level_wdata = mqs_pkg::LVL_RR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         iss_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         iss_v_ff <= issue;
      end
   end

   // current item and issued index
   always_ff @(posedge clock) begin
      iss_idx_ff <= cnt_idx;
      if (q_pop) begin
         cur_ff <= q_item;
      end
   end

   // candidate tracking, lowest slot wins ties
   always_ff @(posedge clock) begin
      if (reset || cand_clear) begin
         c1_found_ff <= 1'b0;
         c2_found_ff <= 1'b0;
         c3_found_ff <= 1'b0;
      end else begin
         if (scan_v && ready_rd && (level_rd == mqs_pkg::LVL_RR) && !c1_found_ff) begin
            c1_found_ff <= 1'b1;
         end
         if (scan_v && ready_rd && (level_rd == mqs_pkg::LVL_LCFS)
             && (!c2_found_ff || (info_rd.order > c2_order_ff))) begin
            c2_found_ff <= 1'b1;
         end
         if (rk_valid && rk_cand && (!c3_found_ff || (rk_rank < c3_rank_ff))) begin
            c3_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_v && ready_rd && (level_rd == mqs_pkg::LVL_RR) && !c1_found_ff) begin
         c1_idx_ff <= iss_idx_ff;
      end
      if (scan_v && ready_rd && (level_rd == mqs_pkg::LVL_LCFS)
          && (!c2_found_ff || (info_rd.order > c2_order_ff))) begin
         c2_idx_ff   <= iss_idx_ff;
         c2_order_ff <= info_rd.order;
      end
      if (rk_valid && rk_cand && (!c3_found_ff || (rk_rank < c3_rank_ff))) begin
         c3_idx_ff  <= rk_idx;
         c3_rank_ff <= rk_rank;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= any_found;
         rsp_slot_ff  <= mqs_pkg::SLOT_W'(pick_idx);
         rsp_level_ff <= pick_level;
         rsp_rank_ff  <= pick_rank;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_slot  = rsp_slot_ff;
   assign rsp_served_level = rsp_level_ff;
   assign rsp_chosen_rank  = rsp_rank_ff;
   assign clearing         = (state_ff == ST_CLEAR);

   // entry tables
   mqs_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_ready_ram (
      .clock(clock), .we(ready_we), .waddr(wr_addr), .wdata(ready_wdata),
      .raddr(rd_addr), .rdata(ready_rd)
   );

   mqs_ram #(.WIDTH(mqs_pkg::LEVEL_W), .DEPTH(TABLE_ENTRIES)) u_level_ram (
      .clock(clock), .we(level_we), .waddr(wr_addr), .wdata(level_wdata),
      .raddr(rd_addr), .rdata(level_rd)
   );

   mqs_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_ENTRIES)) u_info_ram (
      .clock(clock), .we(info_we), .waddr(wr_addr), .wdata(q_item.info),
      .raddr(rd_addr), .rdata(info_raw)
   );

   mqs_ram #(.WIDTH(mqs_pkg::TENTHS_W), .DEPTH(TABLE_ENTRIES)) u_tenths_ram (
      .clock(clock), .we(tenths_we), .waddr(wr_addr), .wdata(tenths_wdata),
      .raddr(rd_addr), .rdata(tenths_rd)
   );

   mqs_ram #(.WIDTH(WEIGHT_T), .DEPTH(TABLE_ENTRIES)) u_weight_ram (
      .clock(clock), .we(weight_we), .waddr(wr_addr), .wdata(weight_wdata),
      .raddr(rd_addr), .rdata(weight_raw)
   );

   // rank pipeline for the best-job-first level
   mqs_rank #(.IDX_W(IDX_W)) u_rank (
      .clock(clock),
      .reset(reset),
      .in_valid(scan_v),
      .in_idx(iss_idx_ff),
      .in_cand(ready_rd && (level_rd == mqs_pkg::LVL_BJF)),
      .in_info(info_rd),
      .in_tenths(tenths_rd),
      .in_weights(mqs_pkg::weight_type'(weight_raw)),
      .out_valid(rk_valid),
      .out_idx(rk_idx),
      .out_cand(rk_cand),
      .out_rank(rk_rank),
      .busy(rank_busy)
   );

   // checks
   `MQS_ASSERT_IMP(a_rsp_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result register overwritten")
   `MQS_ASSERT_IMP(a_rank_in_scan, clock, reset, rank_busy, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "rank pipeline active outside a scan")
   `MQS_ASSERT_NXT(a_age_after_pick, clock, reset, rsp_load && any_found, state_ff == ST_AGE, "pick not followed by aging pass")
   `MQS_ASSERT_IMP(a_rank_only_bjf, clock, reset, rsp_valid_ff && (rsp_level_ff != mqs_pkg::SRV_BJF), rsp_rank_ff == '0, "rank set outside best-job-first level")

endmodule

>>> dv/multilevel_queue_scheduler_test.sv
// testbench of the multilevel queue scheduler: directed level, tie and aging cases, then random traffic
// depends on mqs_pkg and multilevel_queue_scheduler; a local task table predicts every pick
`timescale 1ns / 100ps

module multilevel_queue_scheduler_test;
   import mqs_pkg::*;

   localparam int SLOTS       = 64;
   localparam int SETTLE      = 2 * SLOTS + 80;
   localparam int STALL_LIMIT = 20000;
   localparam int MAX_SHOWN   = 10;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [LEVEL_W-1:0]  level;
      logic [RANK_W-1:0]   rank;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic req_runnable = 1'b0;
   logic [LEVEL_W-1:0] req_queue_level = '0;
   logic [ORDER_W-1:0] req_arrival_order = '0;
   logic [TIME_W-1:0] req_time_stamp = '0;
   logic [SIZE_W-1:0] req_task_size = '0;
   logic [PRIO_W-1:0] req_base_priority = '0;
   logic [WEIGHT_W-1:0] req_weight_priority = '0;
   logic [WEIGHT_W-1:0] req_weight_arrival = '0;
   logic [WEIGHT_W-1:0] req_weight_executed = '0;
   logic [WEIGHT_W-1:0] req_weight_size = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [SLOT_W-1:0] rsp_chosen_slot;
   logic [LEVEL_W-1:0] rsp_served_level;
   logic [RANK_W-1:0] rsp_chosen_rank;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   multilevel_queue_scheduler DUT (.*);

   // predicted task table and registers
   logic               ready_tab   [SLOTS];
   logic [LEVEL_W-1:0] level_tab   [SLOTS];
   logic [ORDER_W-1:0] order_tab   [SLOTS];
   logic [TIME_W-1:0]  created_tab [SLOTS];
   logic [TENTHS_W-1:0] tenths_tab [SLOTS];
   logic [SIZE_W-1:0]  size_tab    [SLOTS];
   logic [PRIO_W-1:0]  prio_tab    [SLOTS];
   weight_type         weight_tab  [SLOTS];
   bit                 written     [SLOTS];
   logic [TIME_W-1:0]   aging_reg;
   logic [WEIGHT_W-1:0] def_wt_reg;
   logic [WEIGHT_W-1:0] def_size_wt_reg;

   pick_type picks_due[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int items_sent = 0;
   int picks_seen = 0;
   int picks_hit = 0;
   int stall_count = 0;
   logic [TIME_W-1:0] tick = 32'd5000;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count > STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         picks_seen++;
         if (picks_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result: found %0d slot %0d", rsp_found, rsp_chosen_slot);
         end else begin
            want = picks_due.pop_front();
            if (want.found) picks_hit++;
            if (rsp_found !== want.found || rsp_chosen_slot !== want.slot ||
                rsp_served_level !== want.level || rsp_chosen_rank !== want.rank) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: exp f%0d s%0d l%0d r%0d got f%0d s%0d l%0d r%0d",
                     want.found, want.slot, want.level, want.rank, rsp_found,
                     rsp_chosen_slot, rsp_served_level, rsp_chosen_rank);
            end
         end
      end
   end

   function automatic logic [RANK_W-1:0] rank_of(int i);
      logic [63:0] base;
      logic [63:0] total;
      logic [63:0] r;
      base = 64'(prio_tab[i]) * 64'(weight_tab[i].wt_prio)
           + 64'(created_tab[i]) * 64'(weight_tab[i].wt_arrival)
           + 64'(size_tab[i]) * 64'(weight_tab[i].wt_size);
      total = base * 64'd10 + 64'(tenths_tab[i]) * 64'(weight_tab[i].wt_exec);
      r = total / 64'd2560;
      return (r > {14'd0, {RANK_W{1'b1}}}) ? {RANK_W{1'b1}} : r[RANK_W-1:0];
   endfunction

   // apply one accepted command to the predicted table
   task automatic apply_item(item_type it);
      pick_type p;
      logic [RANK_W-1:0] r;
      int s;
      s = int'(it.slot);
      case (it.op)
         OP_WRITE: begin
            ready_tab[s] = it.runnable;
            level_tab[s] = it.level;
            order_tab[s] = it.info.order;
            created_tab[s] = it.info.created;
            size_tab[s] = it.info.size;
            prio_tab[s] = it.info.prio;
            tenths_tab[s] = '0;
            weight_tab[s] = '{def_size_wt_reg, def_wt_reg, def_wt_reg, def_wt_reg};
            written[s] = 1'b1;
         end
         OP_WEIGHTS: weight_tab[s] = it.weights;
         OP_YIELD: begin
            ready_tab[s] = 1'b1;
            if (tenths_tab[s] != '1) tenths_tab[s] = tenths_tab[s] + 1'b1;
         end
         default: begin
            p = '0;
            for (int i = 0; i < SLOTS && !p.found; i++)
               if (ready_tab[i] && level_tab[i] == LVL_RR)
                  p = '{1'b1, SLOT_W'(i), SRV_RR, '0};
            if (!p.found)
               for (int i = 0; i < SLOTS; i++)
                  if (ready_tab[i] && level_tab[i] == LVL_LCFS &&
                      (!p.found || order_tab[i] > order_tab[p.slot]))
                     p = '{1'b1, SLOT_W'(i), SRV_LCFS, '0};
            if (!p.found)
               for (int i = 0; i < SLOTS; i++)
                  if (ready_tab[i] && level_tab[i] == LVL_BJF) begin
                     r = rank_of(i);
                     if (!p.found || r < p.rank) p = '{1'b1, SLOT_W'(i), SRV_BJF, r};
                  end
            // aging only after a successful pick
            if (p.found) begin
               ready_tab[p.slot] = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (level_tab[i] != LVL_EMPTY && level_tab[i] != LVL_RR &&
                      (it.info.created - created_tab[i]) > aging_reg)
                     level_tab[i] = LVL_RR;
            end
            picks_due.push_back(p);
         end
      endcase
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.op;
      req_slot <= it.slot;
      req_runnable <= it.runnable;
      req_queue_level <= it.level;
      req_arrival_order <= it.info.order;
      req_time_stamp <= it.info.created;
      req_task_size <= it.info.size;
      req_base_priority <= it.info.prio;
      req_weight_priority <= it.weights.wt_prio;
      req_weight_arrival <= it.weights.wt_arrival;
      req_weight_executed <= it.weights.wt_exec;
      req_weight_size <= it.weights.wt_size;
      do @(posedge clock); while (!req_ready);
      apply_item(it);
      items_sent++;
   endtask

   function automatic item_type entry_item(int s, logic run, logic [1:0] lvl,
         logic [31:0] order, logic [31:0] created, logic [31:0] size, logic [6:0] prio);
      item_type it;
      it = '0;
      it.op = OP_WRITE;
      it.slot = SLOT_W'(s);
      it.runnable = run;
      it.level = lvl;
      it.info = '{prio, size, created, order};
      it.weights = '{WEIGHT_W'($urandom), WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                     WEIGHT_W'($urandom)};
      return it;
   endfunction

   function automatic item_type cmd_item(op_type op, int s, logic [31:0] stamp);
      item_type it;
      it = '0;
      it.op = op;
      it.slot = SLOT_W'(s);
      it.runnable = 1'($urandom);
      it.level = LEVEL_W'($urandom);
      it.info = '{PRIO_W'($urandom), $urandom, stamp, $urandom};
      it.weights = '{WEIGHT_W'($urandom), WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                     WEIGHT_W'($urandom)};
      return it;
   endfunction

   // idle sender until all picks arrived and the back end has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (picks_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AGING_LIMIT: aging_reg = val;
         CSR_DEFAULT_WEIGHT: def_wt_reg = val[WEIGHT_W-1:0];
         default: def_size_wt_reg = val[WEIGHT_W-1:0];
      endcase
   endtask

   // schedule with nothing runnable, then round robin lowest slot
   task automatic test_empty_and_rr();
      send_item(cmd_item(OP_SCHED, 0, tick));
      send_item(entry_item(63, 1'b1, LVL_RR, '1, tick, '1, 7'd99));
      send_item(entry_item(5, 1'b1, LVL_RR, '0, tick, '0, 7'd0));
      send_item(entry_item(1, 1'b0, LVL_RR, 32'd7, tick, 32'd9, 7'd3));
      send_item(cmd_item(OP_SCHED, 0, tick));
      send_item(cmd_item(OP_SCHED, 0, tick));
      send_item(cmd_item(OP_SCHED, 0, tick));
   endtask

   // last come level with equal orders, lowest slot wins
   task automatic test_lcfs_ties();
      send_item(entry_item(10, 1'b1, LVL_LCFS, 32'd500, tick, 32'd1, 7'd1));
      send_item(entry_item(4, 1'b1, LVL_LCFS, 32'd500, tick, 32'd1, 7'd1));
      send_item(entry_item(2, 1'b1, LVL_LCFS, 32'd499, tick, 32'd1, 7'd1));
      repeat (4) send_item(cmd_item(OP_SCHED, 0, tick));
   endtask

   // best job level with extreme weights, ties, yield and a level-zero entry
   task automatic test_bjf();
      item_type it;
      send_item(entry_item(20, 1'b1, LVL_BJF, '0, '1, '1, 7'd99));
      send_item(entry_item(21, 1'b1, LVL_BJF, '0, 32'd3, 32'd3, 7'd3));
      send_item(entry_item(22, 1'b1, LVL_BJF, '0, 32'd3, 32'd3, 7'd3));
      send_item(entry_item(23, 1'b1, LVL_EMPTY, '0, tick, '0, 7'd0));
      it = cmd_item(OP_WEIGHTS, 20, tick);
      it.weights = '{'1, '1, '1, '1};
      send_item(it);
      send_item(cmd_item(OP_YIELD, 21, tick));
      send_item(cmd_item(OP_YIELD, 21, tick));
      repeat (4) send_item(cmd_item(OP_SCHED, 0, tick));
   endtask

   // old entries move to level one after a pick
   task automatic test_aging();
      send_item(entry_item(30, 1'b1, LVL_BJF, '0, 32'd100, 32'd0, 7'd0));
      send_item(entry_item(31, 1'b1, LVL_LCFS, 32'd1, 32'd100, 32'd0, 7'd0));
      send_item(entry_item(32, 1'b1, LVL_LCFS, 32'd2, 32'd900, 32'd0, 7'd0));
      send_item(cmd_item(OP_SCHED, 0, 32'd1101));
      send_item(cmd_item(OP_SCHED, 0, 32'd1101));
      send_item(cmd_item(OP_SCHED, 0, 32'd1101));
   endtask

   // mostly well formed traffic on a few hot slots
   task automatic test_random(int count);
      int s;
      int k;
      logic [31:0] born;
      for (int n = 0; n < count; n++) begin
         s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11);
         k = $urandom_range(99);
         born = ($urandom_range(19) == 0) ? $urandom : tick - $urandom_range(1500);
         if (k < 33)
            send_item(entry_item(s, $urandom_range(5) != 0,
               ($urandom_range(15) == 0) ? LVL_EMPTY : 2'($urandom_range(1, 3)),
               $urandom_range(15), born,
               ($urandom_range(1) == 0) ? $urandom_range(2000) : $urandom,
               7'($urandom_range(99))));
         else if (k < 43)
            send_item(cmd_item(OP_WEIGHTS, s, tick));
         else if (k < 65 && written[s])
            send_item(cmd_item(OP_YIELD, s, tick));
         else if (k < 65)
            send_item(cmd_item(OP_WEIGHTS, s, tick));
         else begin
            tick = tick + $urandom_range(300);
            send_item(cmd_item(OP_SCHED, 0, tick));
         end
      end
   endtask

   initial begin
      foreach (ready_tab[i]) begin
         ready_tab[i] = 1'b0;
         level_tab[i] = LVL_EMPTY;
         tenths_tab[i] = '0;
         written[i] = 1'b0;
      end
      aging_reg = AGING_LIMIT_RST;
      def_wt_reg = DEF_WEIGHT_RST;
      def_size_wt_reg = DEF_SIZE_WEIGHT_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_rr();
      test_lcfs_ties();
      test_bjf();
      test_aging();
      drain();

      csr_write(CSR_AGING_LIMIT, '1);
      csr_write(CSR_DEFAULT_WEIGHT, 32'hFFFF);
      csr_write(CSR_DEFAULT_SIZE_WEIGHT, 32'd0);
      test_random(270);
      drain();

      idle_pct = 82;
      csr_write(CSR_AGING_LIMIT, 32'd0);
      csr_write(CSR_DEFAULT_WEIGHT, 32'd0);
      csr_write(CSR_DEFAULT_SIZE_WEIGHT, 32'hFFFF);
      test_random(270);
      drain();

      idle_pct = 0;
      stall_pct = 82;
      csr_write(CSR_AGING_LIMIT, 32'd800);
      csr_write(CSR_DEFAULT_WEIGHT, $urandom_range(65535));
      csr_write(CSR_DEFAULT_SIZE_WEIGHT, $urandom_range(65535));
      test_random(270);
      drain();

      idle_pct = 13;
      stall_pct = 13;
      csr_write(CSR_AGING_LIMIT, 32'd1000);
      csr_write(CSR_DEFAULT_WEIGHT, 32'd51);
      csr_write(CSR_DEFAULT_SIZE_WEIGHT, 32'd256);
      test_random(270);
      drain();

      $display("covered %0d requests and %0d picks (%0d found) over four register settings",
         items_sent, picks_seen, picks_hit);
      $display("mismatches: %0d, picks still owed: %0d", mismatches, picks_due.size());
      if (mismatches == 0 && picks_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mqs_pkg.sv
hw/rtl/mqs_ram.sv
hw/rtl/mqs_rank.sv
hw/rtl/mqs_front.sv
hw/rtl/mqs_back.sv
hw/rtl/multilevel_queue_scheduler.sv
dv/multilevel_queue_scheduler_test.sv
